FILE: hdl/ecsc_pkg.sv
package ecsc_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KANJI_EN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALFKANA_EN = 1'b1;

    localparam logic [7:0] SS2_BYTE = 8'h8E;
    localparam logic [7:0] LF_BYTE = 8'h0A;
    localparam logic [7:0] CR_BYTE = 8'h0D;

    localparam logic [7:0] ROW_SPLIT = 8'h5F;
    localparam logic [7:0] ROW_ADD = 8'h80;
    localparam logic [7:0] ROW_EVEN_OFS = 8'h70;
    localparam logic [7:0] ROW_ODD_OFS = 8'h71;
    localparam logic [7:0] CELL_EVEN_OFS = 8'h7E;
    localparam logic [7:0] CELL_SKIP = 8'h60;
    localparam logic [7:0] CELL_ODD_OFS = 8'h1F;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,
        PEND_KANJI = 3'b010,
        PEND_KANA  = 3'b100
    } t_pend;

    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       last;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [15:0] map_pair(input logic [7:0] lead, input logic [7:0] trail);
        logic [7:0] r;
        logic [7:0] c;
        logic [7:0] s1;
        logic [7:0] s2;
        r = {1'b0, lead[6:0]};
        c = {1'b0, trail[6:0]};
        if (r >= ROW_SPLIT) begin
            r = r + ROW_ADD;
        end
        if (!r[0]) begin
            s1 = {1'b0, r[7:1]} + ROW_EVEN_OFS;
            s2 = c + CELL_EVEN_OFS;
        end else begin
            if (c >= CELL_SKIP) begin
                c = c + 8'd1;
            end
            s1 = {1'b0, r[7:1]} + ROW_ODD_OFS;
            s2 = c + CELL_ODD_OFS;
        end
        return {s1, s2};
    endfunction

endpackage

FILE: hdl/ecsc_if.sv
interface ecsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source(output valid, output in_byte, output last_in, input ready);
    modport sink(input valid, input in_byte, input last_in, output ready);
endinterface

interface ecsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source(output valid, output out_byte, output out_last, input ready);
    modport sink(input valid, input out_byte, input out_last, output ready);
endinterface

FILE: hdl/ecsc_front.sv
module ecsc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_kanji_en,
    input  logic           i_halfkana_en,
    ecsc_in_if.sink        i_in,
    input  ecsc_pkg::t_qstat i_qstat,
    output logic           o_push,
    output ecsc_pkg::t_qent o_ent
);
    import ecsc_pkg::*;

    t_pend       r_pend, n_pend;
    logic [7:0]  r_held, n_held;
    logic        acc;
    logic [15:0] pair;

    assign i_in.ready = !i_qstat.full;
    assign acc = i_in.valid && i_in.ready;
    assign pair = map_pair(r_held, i_in.in_byte);

    always_comb begin
        n_pend = r_pend;
        n_held = r_held;
        o_push = 1'b0;
        o_ent.two = 1'b0;
        o_ent.b0 = i_in.in_byte;
        o_ent.b1 = i_in.in_byte;
        o_ent.last = i_in.last_in;
        if (acc) begin
            n_pend = PEND_NONE;
            case (r_pend)
                PEND_KANJI: begin
                    o_push = 1'b1;
                    o_ent.two = 1'b1;
                    o_ent.b0 = pair[15:8];
                    o_ent.b1 = pair[7:0];
                end
                PEND_KANA: begin
                    o_push = 1'b1;
                end
                default: begin
                    if (i_kanji_en && i_in.in_byte[7]) begin
                        if (!i_in.last_in) begin
                            if (i_halfkana_en && i_in.in_byte == SS2_BYTE) begin
                                n_pend = PEND_KANA;
                            end else begin
                                n_pend = PEND_KANJI;
                                n_held = i_in.in_byte;
                            end
                        end
                    end else if (i_in.in_byte == LF_BYTE) begin
                        o_push = 1'b1;
                        o_ent.two = 1'b1;
                        o_ent.b0 = CR_BYTE;
                        o_ent.b1 = LF_BYTE;
                    end else begin
                        o_push = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_NONE;
            r_held <= '0;
        end else begin
            r_pend <= n_pend;
            r_held <= n_held;
        end
    end
endmodule

FILE: hdl/ecsc_queue.sv
module ecsc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ecsc_pkg::t_qent  i_ent,
    input  logic             i_pop,
    output ecsc_pkg::t_qent  o_head,
    output ecsc_pkg::t_qstat o_qstat
);
    import ecsc_pkg::*;

    t_qent               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wptr, n_wptr;
    logic [Q_PTR_W-1:0]  r_rptr, n_rptr;
    logic [Q_CNT_W-1:0]  r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_qstat.full = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop = i_pop && !o_qstat.empty;
    assign o_head = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + Q_PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + Q_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + Q_CNT_W'(1);
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt <= n_cnt;
        end
    end
endmodule

FILE: hdl/ecsc_back.sv
module ecsc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ecsc_pkg::t_qent  i_head,
    input  ecsc_pkg::t_qstat i_qstat,
    output logic             o_pop,
    ecsc_out_if.source       o_out
);
    import ecsc_pkg::*;

    logic       r_ov, n_ov;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_phase, n_phase;
    logic       ld;

    assign ld = !r_ov || o_out.ready;
    assign o_out.valid = r_ov;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;

    always_comb begin
        n_ov = r_ov;
        n_byte = r_byte;
        n_last = r_last;
        n_phase = r_phase;
        o_pop = 1'b0;
        if (ld) begin
            n_ov = !i_qstat.empty;
            if (!i_qstat.empty) begin
                if (i_head.two && !r_phase) begin
                    n_byte = i_head.b0;
                    n_last = 1'b0;
                    n_phase = 1'b1;
                end else begin
                    n_byte = r_phase ? i_head.b1 : i_head.b0;
                    n_last = i_head.last;
                    n_phase = 1'b0;
                    o_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end
endmodule

FILE: hdl/euc_to_sjis_crlf_converter_top.sv
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    in_byte[7:0], last_in
// o_out     out  valid/ready    out_byte[7:0], out_last
// cfg       in   i_cfg_we       i_cfg_idx[0:0], i_cfg_wdata[0:0]
//
// One input byte per cycle while the queue is not full; LF and kanji trail bytes
// expand to two output transactions, sent in turn by the single output register.
// Output valid comes from the output register, fed from the two-entry queue.
// Synchronous reset clears pending lead, queue and output valid; modes reset to 1.
// Input stalls only when the queue is full; output stalls hold the output register.
module euc_to_sjis_crlf_converter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ecsc_in_if.sink                        i_in,
    ecsc_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [ecsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ecsc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ecsc_pkg::*;

    logic   r_kanji_en;
    logic   r_halfkana_en;
    logic   push, pop;
    t_qent  ent, head;
    t_qstat qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kanji_en <= 1'b1;
            r_halfkana_en <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IDX_KANJI_EN) begin
                r_kanji_en <= i_cfg_wdata[0];
            end
            if (i_cfg_idx == CFG_IDX_HALFKANA_EN) begin
                r_halfkana_en <= i_cfg_wdata[0];
            end
        end
    end

    ecsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kanji_en    (r_kanji_en),
        .i_halfkana_en (r_halfkana_en),
        .i_in          (i_in),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_ent         (ent)
    );

    ecsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (ent),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    ecsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

FILE: hdl/ecsc_checker.sv
module ecsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    a_rst_out_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_rst_in_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed while stalled");
endmodule

bind euc_to_sjis_crlf_converter_top ecsc_checker u_ecsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);

FILE: tb/sjis_stream_checker.sv
`timescale 1ns / 1ps

module sjis_stream_checker
    import ecsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [7:0]            i_out_byte,
    input  logic                  i_out_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_sjis_byte;

    t_sjis_byte sjis_expected[$];

    logic       kanji_on;
    logic       kana_on;
    logic [7:0] lead_hold;
    t_pend      pend;
    int         mismatch_count = 0;

    function automatic logic [15:0] euc_pair_to_sjis(input logic [7:0] lead,
                                                      input logic [7:0] trail);
        int row;
        int col;
        int s1;
        int s2;
        row = int'(lead[6:0]);
        col = int'(trail[6:0]);
        if (row >= 'h5F) begin
            row = row + 'h80;
        end
        if (row % 2 == 0) begin
            s1 = (row >> 1) + 'h70;
            s2 = col + 'h7E;
        end else begin
            if (col >= 'h60) begin
                col = col + 1;
            end
            s1 = (row >> 1) + 'h71;
            s2 = col + 'h1F;
        end
        return {s1[7:0], s2[7:0]};
    endfunction

    task automatic predict_sjis(input logic [7:0] b, input logic l);
        logic [15:0] pair;
        t_pend       was;
        was = pend;
        pend = PEND_NONE;
        if (was == PEND_KANJI) begin
            pair = euc_pair_to_sjis(lead_hold, b);
            sjis_expected.push_back({pair[15:8], 1'b0});
            sjis_expected.push_back({pair[7:0], l});
        end else if (was == PEND_KANA) begin
            sjis_expected.push_back({b, l});
        end else if (kanji_on && b[7]) begin
            // dangling prefix at end of block is dropped
            if (!l) begin
                if (kana_on && b == SS2_BYTE) begin
                    pend = PEND_KANA;
                end else begin
                    pend = PEND_KANJI;
                    lead_hold = b;
                end
            end
        end else if (b == LF_BYTE) begin
            sjis_expected.push_back({CR_BYTE, 1'b0});
            sjis_expected.push_back({LF_BYTE, l});
        end else begin
            sjis_expected.push_back({b, l});
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_sjis_byte want;
        if (!i_rst_n) begin
            kanji_on = 1'b1;
            kana_on = 1'b1;
            lead_hold = '0;
            pend = PEND_NONE;
            sjis_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_KANJI_EN: kanji_on = i_cfg_wdata[0];
                    CFG_IDX_HALFKANA_EN: kana_on = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_sjis(i_in_byte, i_in_last);
            end
            if (i_out_valid && i_out_ready) begin
                if (sjis_expected.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("checker: unexpected transaction byte %h last %b",
                                 i_out_byte, i_out_last);
                    end
                    mismatch_count++;
                end else begin
                    want = sjis_expected.pop_front();
                    if (want.data !== i_out_byte || want.last !== i_out_last) begin
                        if (mismatch_count < 10) begin
                            $display("checker: expected byte %h last %b, got byte %h last %b",
                                     want.data, want.last, i_out_byte, i_out_last);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        o_outstanding <= sjis_expected.size();
        o_mismatches <= mismatch_count;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ecsc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT = 5000;
    localparam int PHASE_ITEMS = 340;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatches;
    int                    outstanding;
    int                    items_sent;
    int                    cycle_count;
    logic                  src_burst;

    ecsc_in_if  in_ch();
    ecsc_out_if out_ch();

    euc_to_sjis_crlf_converter_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    sjis_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_byte    (in_ch.in_byte),
        .i_in_last    (in_ch.last_in),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_byte   (out_ch.out_byte),
        .i_out_last   (out_ch.out_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap(input logic burst);
        int r;
        r = $urandom_range(99);
        if (burst || r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(3, 1);
        end else if (r < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // output side: random stalls plus one long hold-off to back up the block
    initial begin : sink_ctrl
        int  gap;
        int  n;
        logic hold_done;
        logic sink_burst;
        out_ch.ready = 1'b0;
        hold_done = 1'b0;
        sink_burst = 1'b0;
        n = 0;
        while (rst_n !== 1'b1) @(negedge clk);
        forever begin
            if (n % 128 == 0) begin
                sink_burst = ($urandom_range(3) == 0);
            end
            n++;
            gap = pick_gap(sink_burst);
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(negedge clk);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap(src_burst);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.last_in <= l;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic quiesce();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_modes(input logic kanji, input logic kana);
        quiesce();
        write_reg(CFG_IDX_KANJI_EN, kanji);
        write_reg(CFG_IDX_HALFKANA_EN, kana);
    endtask

    task automatic send_random_text(input int count);
        int         sent;
        int         r;
        logic       lastf;
        logic [7:0] lead;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(63) == 0) begin
                src_burst = ~src_burst;
            end
            r = $urandom_range(99);
            lastf = ($urandom_range(15) == 0);
            if (r < 30) begin
                push_byte(8'($urandom_range(8'h7E, 8'h20)), lastf);
                sent += 1;
            end else if (r < 40) begin
                push_byte(LF_BYTE, lastf);
                sent += 1;
            end else if (r < 70) begin
                lead = 8'($urandom_range(8'hFE, 8'hA1));
                push_byte(lead, $urandom_range(19) == 0);
                push_byte(8'($urandom_range(8'hFE, 8'hA1)), lastf);
                sent += 2;
            end else if (r < 82) begin
                push_byte(SS2_BYTE, $urandom_range(19) == 0);
                push_byte(8'($urandom_range(8'hDF, 8'hA1)), lastf);
                sent += 2;
            end else begin
                push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                sent += 1;
            end
        end
    endtask

    initial begin : stimulus
        int waited;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.last_in = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        items_sent = 0;
        src_burst = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default modes after reset
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(LF_BYTE, 1'b0);
        push_byte(CR_BYTE, 1'b0);
        push_byte(LF_BYTE, 1'b1);
        push_byte(8'hB0, 1'b0);
        push_byte(8'hA1, 1'b0);
        push_byte(8'hB1, 1'b0);
        push_byte(8'hE0, 1'b0);
        push_byte(8'hB1, 1'b0);
        push_byte(8'hA1, 1'b1);
        push_byte(8'hDF, 1'b0);
        push_byte(8'hFE, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFE, 1'b0);
        push_byte(LF_BYTE, 1'b0);
        push_byte(SS2_BYTE, 1'b0);
        push_byte(8'hB1, 1'b0);
        push_byte(SS2_BYTE, 1'b0);
        push_byte(LF_BYTE, 1'b1);
        push_byte(SS2_BYTE, 1'b0);
        push_byte(SS2_BYTE, 1'b0);
        push_byte(8'hC0, 1'b1);
        push_byte(SS2_BYTE, 1'b1);
        push_byte(8'hFF, 1'b1);

        set_modes(1'b0, 1'b1);
        push_byte(SS2_BYTE, 1'b0);
        push_byte(8'hB0, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(LF_BYTE, 1'b0);

        set_modes(1'b1, 1'b0);
        push_byte(SS2_BYTE, 1'b0);
        push_byte(8'hA1, 1'b0);
        push_byte(SS2_BYTE, 1'b1);

        // mode change with a prefix pending
        set_modes(1'b1, 1'b1);
        push_byte(8'hB0, 1'b0);
        quiesce();
        write_reg(CFG_IDX_KANJI_EN, 1'b0);
        push_byte(8'hA1, 1'b1);
        set_modes(1'b1, 1'b1);
        push_byte(SS2_BYTE, 1'b0);
        quiesce();
        write_reg(CFG_IDX_HALFKANA_EN, 1'b0);
        push_byte(8'hC1, 1'b1);

        set_modes(1'b1, 1'b1);
        send_random_text(PHASE_ITEMS);
        set_modes(1'b0, 1'b0);
        send_random_text(PHASE_ITEMS);
        set_modes(1'b1, 1'b0);
        send_random_text(PHASE_ITEMS);
        set_modes(1'b0, 1'b1);
        send_random_text(PHASE_ITEMS);
        set_modes(1'b1, 1'b1);
        send_random_text(PHASE_ITEMS);

        in_ch.valid <= 1'b0;
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
